[rtl/mcg_pkg.sv]
// shared types and codes for the midpoint circle generator
// no dependencies; imported by every module of the block

package mcg_pkg;

  // input selector carried in the slave-side tuser
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // beats per octant step in each mode
  localparam int POINTS_PER_STEP = 8;
  localparam int SPANS_PER_STEP  = 4;

  // bit positions in the master-side tuser
  localparam int USER_SPAN_BIT = 0;
  localparam int USER_DONE_BIT = 1;
  localparam int OUT_USER_W    = 2;

  // control that travels with one step from walker to emitter
  typedef struct packed {
    logic fill;
    logic done;
  } step_ctrl_t;

endpackage

[rtl/mcg_walker.sv]
// octant walker: holds x, y, error term, centre and mode between steps
// depends on mcg_pkg

module mcg_walker import mcg_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          kind_i,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_i,
  input  logic                          fill_mode_i,
  output logic                          step_valid_o,
  output logic signed [RADIUS_BITS:0]   step_x_o,
  output logic signed [RADIUS_BITS:0]   step_y_o,
  output logic signed [COORD_BITS-1:0]  step_ox_o,
  output logic signed [COORD_BITS-1:0]  step_oy_o,
  output step_ctrl_t                    step_ctrl_o
);

  localparam int X_W = RADIUS_BITS + 1;
  localparam int E_W = RADIUS_BITS + 4;

  logic signed [X_W-1:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [E_W-1:0]        err_q, err_d;
  logic                         active_q;
  logic                         fill_q, fill_d;
  logic signed [COORD_BITS-1:0] org_x_q, org_x_d, org_y_q, org_y_d;

  logic                         is_start, fire, done;
  logic signed [X_W-1:0]        base_x, base_y;
  logic signed [E_W-1:0]        base_err, y_e, x_e, diff;

  assign is_start = (kind_i == KIND_START);
  assign fire     = accept_i && (is_start || active_q);

  // starting point of this step: freshly loaded or carried over
  always_comb begin
    if (is_start) begin
      base_x   = {1'b0, radius_i};
      base_y   = '0;
      base_err = E_W'(1) - E_W'({1'b0, radius_i});
      org_x_d  = center_x_i;
      org_y_d  = center_y_i;
      fill_d   = fill_mode_i;
    end else begin
      base_x   = cur_x_q;
      base_y   = cur_y_q;
      base_err = err_q;
      org_x_d  = org_x_q;
      org_y_d  = org_y_q;
      fill_d   = fill_q;
    end
  end

  // midpoint update using the new x and y
  always_comb begin
    cur_y_d = base_y + X_W'(1);
    cur_x_d = base_x;
    y_e     = E_W'(cur_y_d);
    x_e     = '0;
    diff    = '0;
    if (base_err[E_W-1]) begin
      err_d = base_err + {y_e[E_W-2:0], 1'b1};
    end else begin
      cur_x_d = base_x - X_W'(1);
      x_e     = E_W'(cur_x_d);
      diff    = y_e - x_e + E_W'(1);
      err_d   = base_err + {diff[E_W-2:0], 1'b0};
    end
  end

  assign done = (cur_x_d < cur_y_d);

  // walker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      err_q    <= '0;
      active_q <= 1'b0;
      fill_q   <= 1'b0;
      org_x_q  <= '0;
      org_y_q  <= '0;
    end else if (fire) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      err_q    <= err_d;
      active_q <= !done;
      fill_q   <= fill_d;
      org_x_q  <= org_x_d;
      org_y_q  <= org_y_d;
    end
  end

  // step handed to the emitter uses the pre-update position
  assign step_valid_o     = fire;
  assign step_x_o         = base_x;
  assign step_y_o         = base_y;
  assign step_ox_o        = org_x_d;
  assign step_oy_o        = org_y_d;
  assign step_ctrl_o.fill = fill_d;
  assign step_ctrl_o.done = done;

`ifndef NO_ASSERTIONS
  // a running circle always sits in the octant x >= y
  a_octant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cur_x_q >= cur_y_q))
    else $error("walker left the octant while active");

  // a step beat while idle leaves the walker untouched
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !is_start && !active_q) |=>
      ($stable(cur_x_q) && $stable(cur_y_q) && $stable(err_q) && !active_q))
    else $error("idle step changed walker state");

  // finishing the final step of a circle clears the active flag
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && done) |=> !active_q)
    else $error("circle finished but walker still active");
`endif

endmodule

[rtl/mcg_emitter.sv]
// emitter: holds one step and plays out its points or spans one beat a cycle
// while the output is not stalled; depends on mcg_pkg

module mcg_emitter import mcg_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic signed [RADIUS_BITS:0]   x_i,
  input  logic signed [RADIUS_BITS:0]   y_i,
  input  logic signed [COORD_BITS-1:0]  ox_i,
  input  logic signed [COORD_BITS-1:0]  oy_i,
  input  step_ctrl_t                    ctrl_i,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS:0]    x_left_o,
  output logic signed [COORD_BITS:0]    x_right_o,
  output logic signed [COORD_BITS:0]    row_y_o,
  output logic                          is_span_o,
  output logic                          last_o,
  output logic                          done_o
);

  localparam int X_W   = RADIUS_BITS + 1;
  localparam int OUT_W = COORD_BITS + 1;
  localparam int SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
  localparam int CNT_W = $clog2(POINTS_PER_STEP);

  // held step
  logic                         snap_valid_q;
  logic signed [X_W-1:0]        sx_q, sy_q;
  logic signed [COORD_BITS-1:0] sox_q, soy_q;
  step_ctrl_t                   sctrl_q;
  logic        [CNT_W-1:0]      cnt_q;

  // output register
  logic                         out_valid_q;
  logic signed [OUT_W-1:0]      xl_q, xr_q, ry_q, xl_d, xr_d, ry_d;
  logic                         span_q, last_q, done_q, last_d;

  logic                         out_free, emit;
  logic        [CNT_W-1:0]      last_idx;
  logic signed [SUM_W-1:0]      ex, ey, eox, eoy;
  logic signed [SUM_W-1:0]      ox_px, ox_mx, ox_py, ox_my, oy_px, oy_mx, oy_py, oy_my;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = snap_valid_q && out_free;
  assign last_idx = sctrl_q.fill ? CNT_W'(SPANS_PER_STEP - 1) : CNT_W'(POINTS_PER_STEP - 1);
  assign last_d   = (cnt_q == last_idx);

  // mirrored coordinates of the held step
  assign ex    = SUM_W'(sx_q);
  assign ey    = SUM_W'(sy_q);
  assign eox   = SUM_W'(sox_q);
  assign eoy   = SUM_W'(soy_q);
  assign ox_px = eox + ex;
  assign ox_mx = eox - ex;
  assign ox_py = eox + ey;
  assign ox_my = eox - ey;
  assign oy_px = eoy + ex;
  assign oy_mx = eoy - ex;
  assign oy_py = eoy + ey;
  assign oy_my = eoy - ey;

  // pick the beat for the current index
  always_comb begin
    xl_d = ox_mx[OUT_W-1:0];
    xr_d = ox_mx[OUT_W-1:0];
    ry_d = oy_py[OUT_W-1:0];
    if (sctrl_q.fill) begin
      case (cnt_q[1:0])
        2'd0: begin
          xl_d = ox_mx[OUT_W-1:0]; xr_d = ox_px[OUT_W-1:0]; ry_d = oy_py[OUT_W-1:0];
        end
        2'd1: begin
          xl_d = ox_my[OUT_W-1:0]; xr_d = ox_py[OUT_W-1:0]; ry_d = oy_px[OUT_W-1:0];
        end
        2'd2: begin
          xl_d = ox_my[OUT_W-1:0]; xr_d = ox_py[OUT_W-1:0]; ry_d = oy_mx[OUT_W-1:0];
        end
        default: begin
          xl_d = ox_mx[OUT_W-1:0]; xr_d = ox_px[OUT_W-1:0]; ry_d = oy_my[OUT_W-1:0];
        end
      endcase
    end else begin
      case (cnt_q)
        3'd0: begin xl_d = ox_mx[OUT_W-1:0]; ry_d = oy_py[OUT_W-1:0]; end
        3'd1: begin xl_d = ox_px[OUT_W-1:0]; ry_d = oy_py[OUT_W-1:0]; end
        3'd2: begin xl_d = ox_my[OUT_W-1:0]; ry_d = oy_px[OUT_W-1:0]; end
        3'd3: begin xl_d = ox_py[OUT_W-1:0]; ry_d = oy_px[OUT_W-1:0]; end
        3'd4: begin xl_d = ox_my[OUT_W-1:0]; ry_d = oy_mx[OUT_W-1:0]; end
        3'd5: begin xl_d = ox_py[OUT_W-1:0]; ry_d = oy_mx[OUT_W-1:0]; end
        3'd6: begin xl_d = ox_mx[OUT_W-1:0]; ry_d = oy_my[OUT_W-1:0]; end
        default: begin xl_d = ox_px[OUT_W-1:0]; ry_d = oy_my[OUT_W-1:0]; end
      endcase
      xr_d = xl_d;
    end
  end

  // step holding register and beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else if (load_i) begin
      snap_valid_q <= 1'b1;
      cnt_q        <= '0;
    end else if (emit) begin
      if (last_d) begin
        snap_valid_q <= 1'b0;
        cnt_q        <= '0;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sx_q    <= x_i;
      sy_q    <= y_i;
      sox_q   <= ox_i;
      soy_q   <= oy_i;
      sctrl_q <= ctrl_i;
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      xl_q   <= xl_d;
      xr_q   <= xr_d;
      ry_q   <= ry_d;
      span_q <= sctrl_q.fill;
      last_q <= last_d;
      done_q <= last_d && sctrl_q.done;
    end
  end

  assign busy_o      = snap_valid_q;
  assign out_valid_o = out_valid_q;
  assign x_left_o    = xl_q;
  assign x_right_o   = xr_q;
  assign row_y_o     = ry_q;
  assign is_span_o   = span_q;
  assign last_o      = last_q;
  assign done_o      = done_q;

`ifndef NO_ASSERTIONS
  // a new step never overwrites one still being played out
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !snap_valid_q)
    else $error("step loaded while emitter busy");

  // circle done only ever rides on the last beat of a step
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> last_q)
    else $error("circle done without end of step");

  // span steps never count past their four beats
  a_span_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid_q && sctrl_q.fill) |-> (cnt_q < CNT_W'(SPANS_PER_STEP)))
    else $error("span beat index out of range");
`endif

endmodule

[rtl/midpoint_circle_generator_core.sv]
// top level of the midpoint circle generator: stream ports, walker and emitter
// depends on mcg_pkg, mcg_walker, mcg_emitter

// Midpoint circle rasteriser, one octant step per input beat. A start beat
// (tuser = 0) loads centre, radius and fill mode and plays out the first step;
// each step beat (tuser = 1) plays out the next one, and a step beat while no
// circle is running is taken and gives nothing. A step produces 8 point beats
// in outline mode or 4 span beats in fill mode, one per cycle while the output
// is not stalled. Each step is first loaded into the emitter, and the next
// input beat is only taken once the last beat of the current step has moved
// into the output register. tlast marks the last beat of a step, and circle
// done in tuser is set on the last beat of the final step. No state needs
// clearing after reset.

module midpoint_circle_generator_core import mcg_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // center_x, center_y, radius, fill_mode, zero pad
  input  logic [((2*COORD_BITS+RADIUS_BITS+1+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // x_left, x_right, row_y, zero pad
  output logic [((3*(COORD_BITS+1)+7)/8)*8-1:0] m_axis_tdata,
  // is_span, circle_done
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int OUT_W      = COORD_BITS + 1;
  localparam int OUT_DATA_W = ((3*OUT_W+7)/8)*8;
  localparam int CY_LO      = COORD_BITS;
  localparam int R_LO       = 2*COORD_BITS;
  localparam int FILL_BIT   = 2*COORD_BITS + RADIUS_BITS;

  logic                           accept, busy, step_valid;
  logic signed [RADIUS_BITS:0]    step_x, step_y;
  logic signed [COORD_BITS-1:0]   step_ox, step_oy;
  step_ctrl_t                     step_ctrl;
  logic signed [OUT_W-1:0]        x_left, x_right, row_y;
  logic                           is_span, circle_done;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // walker
  mcg_walker #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (s_axis_tuser),
    .center_x_i  (s_axis_tdata[COORD_BITS-1:0]),
    .center_y_i  (s_axis_tdata[CY_LO +: COORD_BITS]),
    .radius_i    (s_axis_tdata[R_LO +: RADIUS_BITS]),
    .fill_mode_i (s_axis_tdata[FILL_BIT]),
    .step_valid_o(step_valid),
    .step_x_o    (step_x),
    .step_y_o    (step_y),
    .step_ox_o   (step_ox),
    .step_oy_o   (step_oy),
    .step_ctrl_o (step_ctrl)
  );

  // emitter
  mcg_emitter #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step_valid),
    .x_i        (step_x),
    .y_i        (step_y),
    .ox_i       (step_ox),
    .oy_i       (step_oy),
    .ctrl_i     (step_ctrl),
    .busy_o     (busy),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .x_left_o   (x_left),
    .x_right_o  (x_right),
    .row_y_o    (row_y),
    .is_span_o  (is_span),
    .last_o     (m_axis_tlast),
    .done_o     (circle_done)
  );

  // output beat packing
  assign m_axis_tdata                = OUT_DATA_W'({row_y, x_right, x_left});
  assign m_axis_tuser[USER_SPAN_BIT] = is_span;
  assign m_axis_tuser[USER_DONE_BIT] = circle_done;

endmodule
